// File: src/npc_pkg.sv
// shared types, widths and palette reset values for the nearest palette color unit
package npc_pkg;

    // palette entries that take part in the search
    localparam int NUM_ENTRIES = 8;

    // field widths
    localparam int RGB_W     = 24;
    localparam int CH_W      = 8;
    localparam int NUM_CH    = 3;
    localparam int SQ_W      = 16;
    localparam int DIST_W    = 18;
    localparam int IDX_W     = 3;
    localparam int CFG_IDX_W = 3;

    // derived sizes
    localparam int PAL_IDX_W   = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
    localparam int TREE_LEVELS = $clog2(NUM_ENTRIES);
    localparam int TREE_SLOTS  = 1 << TREE_LEVELS;

    // largest distance three byte channels can produce
    localparam logic [DIST_W-1:0] MAX_DIST = DIST_W'(195075);

    typedef logic [RGB_W-1:0]  t_rgb;
    typedef logic [CH_W-1:0]   t_chan;
    typedef logic [SQ_W-1:0]   t_sq;
    typedef logic [DIST_W-1:0] t_dist;
    typedef logic [IDX_W-1:0]  t_idx;

    // candidate moving through the minimum search
    typedef struct packed {
        t_idx  idx;
        t_dist distance;
    } t_best;

    // palette contents after reset
    localparam t_rgb PAL_RESET [8] = '{
        24'hd23a34, 24'he8862a, 24'hf2c53a, 24'h4fae53,
        24'h4a6fe0, 24'h9a5ac2, 24'hf0f0ea, 24'h2a2333
    };

endpackage

// File: src/npc_pixel_if.sv
// stream channel carrying input pixels
interface npc_pixel_if import npc_pkg::*;;

    logic valid;
    logic ready;
    t_rgb pixel_rgb;

    modport source (output valid, output pixel_rgb, input ready);
    modport sink   (input valid, input pixel_rgb, output ready);

endinterface

// File: src/npc_match_if.sv
// stream channel carrying nearest palette match results
interface npc_match_if import npc_pkg::*;;

    logic  valid;
    logic  ready;
    t_idx  match_index;
    t_rgb  match_color;
    t_dist match_distance;

    modport source (output valid, output match_index, output match_color,
                    output match_distance, input ready);
    modport sink   (input valid, input match_index, input match_color,
                    input match_distance, output ready);

endinterface

// File: src/npc_dist_unit.sv
// three stage squared distance pipeline, one lane per palette entry
module npc_dist_unit import npc_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_rgb  i_pixel,
    input  t_rgb  i_palette [NUM_ENTRIES],
    output logic  o_valid,
    input  logic  i_ready,
    output t_dist o_dist [NUM_ENTRIES]
);

    logic  r_v1, r_v2, r_v3;
    logic  w_rdy1, w_rdy2, w_rdy3;
    t_chan r_diff [NUM_ENTRIES][NUM_CH];
    t_chan n_diff [NUM_ENTRIES][NUM_CH];
    t_sq   r_sq   [NUM_ENTRIES][NUM_CH];
    t_sq   n_sq   [NUM_ENTRIES][NUM_CH];
    t_dist r_dist [NUM_ENTRIES];
    t_dist n_dist [NUM_ENTRIES];

    // a stage takes a new beat when it is empty or its beat moves on
    assign w_rdy3  = !r_v3 || i_ready;
    assign w_rdy2  = !r_v2 || w_rdy3;
    assign w_rdy1  = !r_v1 || w_rdy2;
    assign o_ready = w_rdy1;

    // absolute channel differences
    always_comb begin
        t_chan p;
        t_chan q;
        for (int e = 0; e < NUM_ENTRIES; e++) begin
            for (int c = 0; c < NUM_CH; c++) begin
                p = i_pixel[c*CH_W +: CH_W];
                q = i_palette[e][c*CH_W +: CH_W];
                n_diff[e][c] = (p > q) ? (p - q) : (q - p);
            end
        end
    end

    // channel squares
    always_comb begin
        for (int e = 0; e < NUM_ENTRIES; e++) begin
            for (int c = 0; c < NUM_CH; c++) begin
                n_sq[e][c] = SQ_W'(r_diff[e][c]) * SQ_W'(r_diff[e][c]);
            end
        end
    end

    // sum over red, green and blue
    always_comb begin
        for (int e = 0; e < NUM_ENTRIES; e++) begin
            n_dist[e] = DIST_W'(r_sq[e][0]) + DIST_W'(r_sq[e][1]) + DIST_W'(r_sq[e][2]);
        end
    end

    // stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_rdy1) r_v1 <= i_valid;
            if (w_rdy2) r_v2 <= r_v1;
            if (w_rdy3) r_v3 <= r_v2;
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        if (w_rdy1) r_diff <= n_diff;
        if (w_rdy2) r_sq   <= n_sq;
        if (w_rdy3) r_dist <= n_dist;
    end

    assign o_valid = r_v3;
    assign o_dist  = r_dist;

endmodule

// File: src/npc_min_tree.sv
// registered pairwise minimum tree, one stage per tree level, lower index wins ties
module npc_min_tree import npc_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_dist i_dist [NUM_ENTRIES],
    output logic  o_valid,
    input  logic  i_ready,
    output t_best o_best
);

    // heap layout: node n has children 2n+1 and 2n+2, leaves follow the internal nodes
    logic  r_valid [TREE_LEVELS];
    logic  w_vin   [TREE_LEVELS+1];
    logic  w_rdy   [TREE_LEVELS+1];
    t_best r_node  [TREE_SLOTS-1];
    t_best n_node  [TREE_SLOTS-1];
    t_best w_all   [2*TREE_SLOTS-1];

    // valid and ready along the levels, level 0 is the root
    always_comb begin
        w_rdy[0]           = i_ready;
        w_vin[TREE_LEVELS] = i_valid;
        for (int lv = 0; lv < TREE_LEVELS; lv++) begin
            w_rdy[lv+1] = !r_valid[lv] || w_rdy[lv];
            w_vin[lv]   = r_valid[lv];
        end
    end
    assign o_ready = w_rdy[TREE_LEVELS];

    // leaves from the distance lanes, unused slots padded so they never win
    always_comb begin
        for (int n = 0; n < TREE_SLOTS-1; n++) begin
            w_all[n] = r_node[n];
        end
        for (int k = 0; k < TREE_SLOTS; k++) begin
            if (k < NUM_ENTRIES) begin
                w_all[TREE_SLOTS-1+k] = '{idx: IDX_W'(k), distance: i_dist[k]};
            end else begin
                w_all[TREE_SLOTS-1+k] = '{idx: IDX_W'(k), distance: '1};
            end
        end
    end

    // the right child replaces the left one only when strictly closer
    always_comb begin
        for (int n = 0; n < TREE_SLOTS-1; n++) begin
            if (w_all[2*n+2].distance < w_all[2*n+1].distance) begin
                n_node[n] = w_all[2*n+2];
            end else begin
                n_node[n] = w_all[2*n+1];
            end
        end
    end

    // level valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int lv = 0; lv < TREE_LEVELS; lv++) begin
                r_valid[lv] <= 1'b0;
            end
        end else begin
            for (int lv = 0; lv < TREE_LEVELS; lv++) begin
                if (w_rdy[lv+1]) r_valid[lv] <= w_vin[lv+1];
            end
        end
    end

    // node payload, each level loads when it may take a beat
    always_ff @(posedge i_clk) begin
        for (int lv = 0; lv < TREE_LEVELS; lv++) begin
            for (int j = 0; j < (1 << lv); j++) begin
                if (w_rdy[lv+1]) r_node[(1 << lv) - 1 + j] <= n_node[(1 << lv) - 1 + j];
            end
        end
    end

    assign o_valid = r_valid[0];
    assign o_best  = r_node[0];

    // the winner is always a real palette entry
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ({1'b0, o_best.idx} < (IDX_W+1)'(NUM_ENTRIES)))
        else $error("min tree picked a padding slot");

    // a stalled root keeps its beat
    a_root_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_best))
        else $error("min tree root changed while stalled");

    // an accepted beat lands in the deepest level
    a_leaf_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> r_valid[TREE_LEVELS-1])
        else $error("min tree dropped an accepted beat");

endmodule

// File: src/nearest_palette_color_unit.sv
// top level of the nearest palette color unit: palette registers, pipeline and output register
// Finds, for every RGB888 pixel beat, the closest of NUM_ENTRIES palette colors by squared
// Euclidean distance and returns its index, its color and the distance; on equal distance the
// lower index wins. One pixel is accepted per clock whenever the result side keeps up. The
// pipeline is made of the per-entry difference, square and sum stages, one register stage per
// level of the pairwise minimum tree, and the output register that also picks the palette color.
// Every stage holds its beat under back pressure and empty stages fill, so a stall loses and
// repeats nothing. Palette registers are written through i_cfg_we, i_cfg_index and i_cfg_data;
// the user must write them only while no beat is in flight, the block does not enforce this.
// Writes to an index past the palette are ignored.
module nearest_palette_color_unit import npc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    npc_pixel_if.sink            i_pix,
    npc_match_if.source          o_match,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  t_rgb                 i_cfg_data
);

    t_rgb  r_palette [NUM_ENTRIES];
    t_dist w_dist    [NUM_ENTRIES];
    logic  w_dist_valid, w_dist_ready;
    logic  w_tree_valid, w_tree_ready;
    t_best w_best;
    logic  r_out_valid;
    t_idx  r_out_idx;
    t_rgb  r_out_color;
    t_dist r_out_dist;

    // palette registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int e = 0; e < NUM_ENTRIES; e++) begin
                r_palette[e] <= PAL_RESET[e];
            end
        end else if (i_cfg_we) begin
            for (int e = 0; e < NUM_ENTRIES; e++) begin
                if (i_cfg_index == CFG_IDX_W'(e)) r_palette[e] <= i_cfg_data;
            end
        end
    end

    // per-entry distances
    npc_dist_unit u_dist (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_pix.valid),
        .o_ready   (i_pix.ready),
        .i_pixel   (i_pix.pixel_rgb),
        .i_palette (r_palette),
        .o_valid   (w_dist_valid),
        .i_ready   (w_dist_ready),
        .o_dist    (w_dist)
    );

    // nearest entry
    npc_min_tree u_tree (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_dist_valid),
        .o_ready (w_dist_ready),
        .i_dist  (w_dist),
        .o_valid (w_tree_valid),
        .i_ready (w_tree_ready),
        .o_best  (w_best)
    );

    // output register with palette color lookup
    assign w_tree_ready = !r_out_valid || o_match.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_tree_ready) begin
            r_out_valid <= w_tree_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_tree_ready) begin
            r_out_idx   <= w_best.idx;
            r_out_dist  <= w_best.distance;
            r_out_color <= r_palette[w_best.idx[PAL_IDX_W-1:0]];
        end
    end

    assign o_match.valid          = r_out_valid;
    assign o_match.match_index    = r_out_idx;
    assign o_match.match_color    = r_out_color;
    assign o_match.match_distance = r_out_dist;

    // no result can lie beyond the largest byte distance
    a_dist_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_match.valid |-> (o_match.match_distance <= MAX_DIST))
        else $error("match distance out of range");

endmodule

// File: test/testbench.sv
// self-checking testbench for the nearest palette color unit
`timescale 1ns / 100ps

module testbench import npc_pkg::*;;

    localparam int STALL_LIMIT   = 2000;
    localparam int DRAIN_CYCLES  = 8;
    localparam int PHASE_PIXELS  = 305;
    localparam int NUM_PHASES    = 6;
    localparam int REPORT_LINES  = 30;

    // palette register indexes on the write port
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PALETTE_0, REG_PALETTE_1, REG_PALETTE_2, REG_PALETTE_3,
        REG_PALETTE_4, REG_PALETTE_5, REG_PALETTE_6, REG_PALETTE_7
    } t_palette_reg;

    // ways of filling the palette between random phases
    typedef enum logic [1:0] {
        PAL_RANDOM, PAL_CORNERS, PAL_CLUSTER, PAL_UNIFORM
    } t_palette_kind;

    typedef enum logic {ROW_PIXEL, ROW_WRITE} t_row_kind;

    typedef struct packed {
        t_idx  idx;
        t_rgb  color;
        t_dist distance;
    } t_match;

    typedef struct packed {
        t_rgb   pixel;
        t_match want;
    } t_pending_match;

    typedef struct packed {
        t_row_kind    kind;
        t_palette_reg reg_idx;
        t_rgb         value;
        logic         typed;
        t_idx         exp_idx;
        t_rgb         exp_color;
        t_dist        exp_dist;
    } t_directed_row;

    // directed stimulus: reset palette, all-black palette, black/white split, ties
    localparam t_directed_row DIRECTED [37] = '{
        '{ROW_PIXEL, REG_PALETTE_0, PAL_RESET[0], 1'b1, 3'd0, PAL_RESET[0], 18'd0},
        '{ROW_PIXEL, REG_PALETTE_0, PAL_RESET[1], 1'b1, 3'd1, PAL_RESET[1], 18'd0},
        '{ROW_PIXEL, REG_PALETTE_0, PAL_RESET[2], 1'b1, 3'd2, PAL_RESET[2], 18'd0},
        '{ROW_PIXEL, REG_PALETTE_0, PAL_RESET[3], 1'b1, 3'd3, PAL_RESET[3], 18'd0},
        '{ROW_PIXEL, REG_PALETTE_0, PAL_RESET[4], 1'b1, 3'd4, PAL_RESET[4], 18'd0},
        '{ROW_PIXEL, REG_PALETTE_0, PAL_RESET[5], 1'b1, 3'd5, PAL_RESET[5], 18'd0},
        '{ROW_PIXEL, REG_PALETTE_0, PAL_RESET[6], 1'b1, 3'd6, PAL_RESET[6], 18'd0},
        '{ROW_PIXEL, REG_PALETTE_0, PAL_RESET[7], 1'b1, 3'd7, PAL_RESET[7], 18'd0},
        '{ROW_PIXEL, REG_PALETTE_0, 24'h000000, 1'b0, 3'd0, 24'h0, 18'd0},
        '{ROW_PIXEL, REG_PALETTE_0, 24'hffffff, 1'b0, 3'd0, 24'h0, 18'd0},
        '{ROW_PIXEL, REG_PALETTE_0, 24'h808080, 1'b0, 3'd0, 24'h0, 18'd0},
        '{ROW_WRITE, REG_PALETTE_0, 24'h000000, 1'b0, 3'd0, 24'h0, 18'd0},
        '{ROW_WRITE, REG_PALETTE_1, 24'h000000, 1'b0, 3'd0, 24'h0, 18'd0},
        '{ROW_WRITE, REG_PALETTE_2, 24'h000000, 1'b0, 3'd0, 24'h0, 18'd0},
        '{ROW_WRITE, REG_PALETTE_3, 24'h000000, 1'b0, 3'd0, 24'h0, 18'd0},
        '{ROW_WRITE, REG_PALETTE_4, 24'h000000, 1'b0, 3'd0, 24'h0, 18'd0},
        '{ROW_WRITE, REG_PALETTE_5, 24'h000000, 1'b0, 3'd0, 24'h0, 18'd0},
        '{ROW_WRITE, REG_PALETTE_6, 24'h000000, 1'b0, 3'd0, 24'h0, 18'd0},
        '{ROW_WRITE, REG_PALETTE_7, 24'h000000, 1'b0, 3'd0, 24'h0, 18'd0},
        '{ROW_PIXEL, REG_PALETTE_0, 24'hffffff, 1'b1, 3'd0, 24'h000000, MAX_DIST},
        '{ROW_PIXEL, REG_PALETTE_0, 24'h123456, 1'b0, 3'd0, 24'h0, 18'd0},
        '{ROW_WRITE, REG_PALETTE_1, 24'hffffff, 1'b0, 3'd0, 24'h0, 18'd0},
        '{ROW_WRITE, REG_PALETTE_2, 24'hffffff, 1'b0, 3'd0, 24'h0, 18'd0},
        '{ROW_WRITE, REG_PALETTE_3, 24'hffffff, 1'b0, 3'd0, 24'h0, 18'd0},
        '{ROW_WRITE, REG_PALETTE_4, 24'hffffff, 1'b0, 3'd0, 24'h0, 18'd0},
        '{ROW_WRITE, REG_PALETTE_5, 24'hffffff, 1'b0, 3'd0, 24'h0, 18'd0},
        '{ROW_WRITE, REG_PALETTE_6, 24'hffffff, 1'b0, 3'd0, 24'h0, 18'd0},
        '{ROW_WRITE, REG_PALETTE_7, 24'hffffff, 1'b0, 3'd0, 24'h0, 18'd0},
        '{ROW_PIXEL, REG_PALETTE_0, 24'hffffff, 1'b1, 3'd1, 24'hffffff, 18'd0},
        '{ROW_PIXEL, REG_PALETTE_0, 24'h000000, 1'b1, 3'd0, 24'h000000, 18'd0},
        '{ROW_PIXEL, REG_PALETTE_0, 24'h808080, 1'b0, 3'd0, 24'h0, 18'd0},
        '{ROW_PIXEL, REG_PALETTE_0, 24'h7f7f7f, 1'b0, 3'd0, 24'h0, 18'd0},
        '{ROW_WRITE, REG_PALETTE_6, 24'h000002, 1'b0, 3'd0, 24'h0, 18'd0},
        '{ROW_WRITE, REG_PALETTE_7, 24'h000004, 1'b0, 3'd0, 24'h0, 18'd0},
        '{ROW_PIXEL, REG_PALETTE_0, 24'h000001, 1'b1, 3'd0, 24'h000000, 18'd1},
        '{ROW_PIXEL, REG_PALETTE_0, 24'h000003, 1'b1, 3'd6, 24'h000002, 18'd1},
        '{ROW_PIXEL, REG_PALETTE_0, 24'h000002, 1'b1, 3'd6, 24'h000002, 18'd0}
    };

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    t_rgb                 i_cfg_data;

    npc_pixel_if pix_if ();
    npc_match_if match_if ();

    nearest_palette_color_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pix       (pix_if),
        .o_match     (match_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    t_rgb           palette_mirror [NUM_ENTRIES];
    t_pending_match expected_matches [$];
    int             send_idle_pct;
    int             recv_idle_pct;
    int             mismatches;
    int             pixels_sent;
    int             matches_checked;
    int             palette_writes;
    int             stall_cycles;
    logic           cfg_open;

    always #10 i_clk = ~i_clk;

    // squared distance over the three color bytes
    function automatic t_dist rgb_distance(input t_rgb a, input t_rgb b);
        int sum;
        int dc;
        sum = 0;
        for (int c = 0; c < NUM_CH; c++) begin
            dc = int'(a[CH_W*c +: CH_W]) - int'(b[CH_W*c +: CH_W]);
            sum += dc * dc;
        end
        return t_dist'(sum);
    endfunction

    // nearest entry of the mirrored palette, lower index kept on equal distance
    function automatic t_match nearest_entry(input t_rgb px);
        t_match best;
        t_dist  d;
        best.idx      = '0;
        best.distance = rgb_distance(px, palette_mirror[0]);
        for (int k = 1; k < NUM_ENTRIES; k++) begin
            d = rgb_distance(px, palette_mirror[k]);
            if (d < best.distance) begin
                best.distance = d;
                best.idx      = t_idx'(k);
            end
        end
        best.color = palette_mirror[best.idx];
        return best;
    endfunction

    // move each channel by a random amount within +-spread, clamped to a byte
    function automatic t_rgb nudge_color(input t_rgb base, input int spread);
        t_rgb moved;
        int   v;
        for (int c = 0; c < NUM_CH; c++) begin
            v = int'(base[CH_W*c +: CH_W]) + int'($urandom_range(2 * spread)) - spread;
            if (v < 0) v = 0;
            if (v > 255) v = 255;
            moved[CH_W*c +: CH_W] = t_chan'(v);
        end
        return moved;
    endfunction

    // mix of uniform pixels, pixels on or near an entry, and saturated channels
    function automatic t_rgb random_pixel();
        t_rgb px;
        t_rgb base;
        int   roll;
        roll = $urandom_range(99);
        base = palette_mirror[$urandom_range(NUM_ENTRIES - 1)];
        if (roll < 55) begin
            px = t_rgb'($urandom);
        end else if (roll < 80) begin
            px = nudge_color(base, 3);
        end else if (roll < 90) begin
            px = base;
        end else begin
            for (int c = 0; c < NUM_CH; c++) begin
                case ($urandom_range(2))
                    0: px[CH_W*c +: CH_W] = 8'h00;
                    1: px[CH_W*c +: CH_W] = 8'hff;
                    default: px[CH_W*c +: CH_W] = t_chan'($urandom);
                endcase
            end
        end
        return px;
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatches < REPORT_LINES) $display("[%0t] mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    // one palette write; caller lowers the write enable after the last one
    task automatic write_palette(input t_palette_reg idx, input t_rgb data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        palette_mirror[idx] = data;
        palette_writes++;
    endtask

    // stop sending and wait until every result is back and the pipe is empty
    task automatic drain_pipeline();
        pix_if.valid <= 1'b0;
        while (expected_matches.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // present one pixel beat, record its expectation when it is taken
    task automatic send_pixel(input t_rgb px, input logic typed, input t_match typed_want);
        t_pending_match entry;
        while ($urandom_range(99) < send_idle_pct) begin
            pix_if.valid     <= 1'b0;
            pix_if.pixel_rgb <= t_rgb'($urandom);
            @(posedge i_clk);
        end
        pix_if.valid     <= 1'b1;
        pix_if.pixel_rgb <= px;
        do @(negedge i_clk); while (!pix_if.ready);
        entry.pixel = px;
        entry.want  = typed ? typed_want : nearest_entry(px);
        expected_matches.push_back(entry);
        pixels_sent++;
        @(posedge i_clk);
    endtask

    // rewrite the whole palette in a rotated order
    task automatic load_palette(input t_palette_kind kind);
        t_rgb base;
        t_rgb color;
        int   start;
        int   k;
        drain_pipeline();
        base  = t_rgb'($urandom);
        start = $urandom_range(NUM_ENTRIES - 1);
        for (int j = 0; j < NUM_ENTRIES; j++) begin
            k = (start + j) % NUM_ENTRIES;
            case (kind)
                PAL_CORNERS: color = {{8{k[2]}}, {8{k[1]}}, {8{k[0]}}};
                PAL_CLUSTER: color = nudge_color(base, 2);
                PAL_UNIFORM: color = base;
                default:     color = t_rgb'($urandom);
            endcase
            write_palette(t_palette_reg'(k), color);
        end
        i_cfg_we <= 1'b0;
    endtask

    // receiver back pressure
    always @(posedge i_clk) begin
        match_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // result check and watchdog, sampled mid-cycle so all values are settled
    always @(negedge i_clk) begin
        t_pending_match entry;
        if (i_rst_n && match_if.valid && match_if.ready) begin
            if (expected_matches.size() == 0) begin
                report_mismatch($sformatf("result index %0d color %06h with nothing pending",
                                          match_if.match_index, match_if.match_color));
            end else begin
                entry = expected_matches.pop_front();
                matches_checked++;
                if (match_if.match_index !== entry.want.idx)
                    report_mismatch($sformatf("pixel %06h index got %0d want %0d", entry.pixel,
                                              match_if.match_index, entry.want.idx));
                if (match_if.match_color !== entry.want.color)
                    report_mismatch($sformatf("pixel %06h color got %06h want %06h",
                                              entry.pixel, match_if.match_color,
                                              entry.want.color));
                if (match_if.match_distance !== entry.want.distance)
                    report_mismatch($sformatf("pixel %06h distance got %0d want %0d",
                                              entry.pixel, match_if.match_distance,
                                              entry.want.distance));
            end
        end
        if ((pix_if.valid && pix_if.ready) || (match_if.valid && match_if.ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("timeout: no beat moved for %0d cycles", STALL_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // main sequence
    initial begin
        t_palette_kind phase_kind [NUM_PHASES];
        phase_kind = '{PAL_RANDOM, PAL_CLUSTER, PAL_CORNERS, PAL_CLUSTER, PAL_UNIFORM,
                       PAL_RANDOM};
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_index      = '0;
        i_cfg_data       = '0;
        pix_if.valid     = 1'b0;
        pix_if.pixel_rgb = '0;
        match_if.ready   = 1'b0;
        send_idle_pct    = 27;
        recv_idle_pct    = 58;
        mismatches       = 0;
        pixels_sent      = 0;
        matches_checked  = 0;
        palette_writes   = 0;
        stall_cycles     = 0;
        cfg_open         = 1'b0;
        foreach (palette_mirror[k]) palette_mirror[k] = PAL_RESET[k];

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        foreach (DIRECTED[r]) begin
            if (DIRECTED[r].kind == ROW_WRITE) begin
                if (!cfg_open) begin
                    drain_pipeline();
                    cfg_open = 1'b1;
                end
                write_palette(DIRECTED[r].reg_idx, DIRECTED[r].value);
            end else begin
                if (cfg_open) begin
                    i_cfg_we <= 1'b0;
                    cfg_open = 1'b0;
                end
                send_pixel(DIRECTED[r].value, DIRECTED[r].typed,
                           t_match'{DIRECTED[r].exp_idx, DIRECTED[r].exp_color,
                                    DIRECTED[r].exp_dist});
            end
        end

        // random phases, two palettes per idling pattern
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph / 2)
                0: begin send_idle_pct = 27; recv_idle_pct = 58; end
                1: begin send_idle_pct = 58; recv_idle_pct = 27; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            load_palette(phase_kind[ph]);
            repeat (PHASE_PIXELS) send_pixel(random_pixel(), 1'b0, '0);
        end

        drain_pipeline();
        $display("sent %0d pixels and checked %0d matches over %0d palette writes",
                 pixels_sent, matches_checked, palette_writes);
        $display("palettes: reset, black, black/white, ties, random, clustered, corners, flat");
        if (mismatches == 0 && expected_matches.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatches,
                     expected_matches.size());
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
